// ===== design/mrs_pkg.sv =====
`timescale 1ns / 1ps

package mrs_pkg;

  // Parameter defaults
  localparam int BIT_DEPTH_DEF   = 1024;
  localparam int REG_DEPTH_DEF   = 64;
  localparam int FRAME_DEPTH_DEF = 256;

  localparam int LEN_W     = 9;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam int          BIT_LAST_MAX  = 16'h03E7;
  localparam int          REG_LAST_MAX  = 16'h0063;
  localparam logic [15:0] COIL_ON       = 16'hFF00;
  localparam logic [15:0] COIL_OFF      = 16'h0000;
  localparam logic [7:0]  EXC_FLAG      = 8'h80;
  localparam logic [15:0] REG_INIT_STEP = 16'd100;

  // Function codes
  localparam logic [7:0] FC_READ_COILS     = 8'h01;
  localparam logic [7:0] FC_READ_INPUTS    = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
  localparam logic [7:0] FC_READ_INPUT_REG = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
  localparam logic [7:0] FC_WRITE_REG      = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI    = 8'h10;

  // Exception codes
  localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'h03;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITABLE_LAST = 2'd2;

  // What a finished frame asks for
  localparam logic [2:0] PLAN_DROP        = 3'd0;
  localparam logic [2:0] PLAN_EXC         = 3'd1;
  localparam logic [2:0] PLAN_READ_BITS   = 3'd2;
  localparam logic [2:0] PLAN_READ_REGS   = 3'd3;
  localparam logic [2:0] PLAN_COIL        = 3'd4;
  localparam logic [2:0] PLAN_WRITE_ONE   = 3'd5;
  localparam logic [2:0] PLAN_WRITE_MANY  = 3'd6;

  // Response byte sources
  localparam logic [3:0] SEL_ADDR       = 4'd0;
  localparam logic [3:0] SEL_FUNC       = 4'd1;
  localparam logic [3:0] SEL_EXC_FUNC   = 4'd2;
  localparam logic [3:0] SEL_EXC_CODE   = 4'd3;
  localparam logic [3:0] SEL_BYTE_COUNT = 4'd4;
  localparam logic [3:0] SEL_BIT_DATA   = 4'd5;
  localparam logic [3:0] SEL_REG_HI     = 4'd6;
  localparam logic [3:0] SEL_REG_LO     = 4'd7;
  localparam logic [3:0] SEL_HEAD       = 4'd8;
  localparam logic [3:0] SEL_F10        = 4'd9;
  localparam logic [3:0] SEL_CRC_LO     = 4'd10;
  localparam logic [3:0] SEL_CRC_HI     = 4'd11;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_data;
  } rx_item_t;

  typedef struct packed {
    logic [63:0] tx_bytes;
    logic [3:0]  tx_count;
    logic        last;
    logic [1:0]  led_state;
  } tx_item_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [7:0] silence_ticks;
    logic [5:0] writable_last;
  } cfg_t;

  typedef struct packed {
    logic       rx_open;
    logic       emit;
    logic       emit_last;
    logic [3:0] sel;
    logic       resp_start;
    logic       frame_clear;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       write_one;
    logic       apply_coil;
    logic       reg_rd;
    logic       fb_rd_hi;
    logic       fb_rd_lo;
    logic       reg_wr_many;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       frame_end;
    logic       out_free;
    logic [2:0] plan;
    logic       cnt_last;
    logic       quad_end;
  } ctrl_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/mrs_ram.sv =====
`timescale 1ns / 1ps

module mrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mrs_pkg::FRAME_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

// ===== design/mrs_ctrl.sv =====
`timescale 1ns / 1ps

module mrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  mrs_pkg::ctrl_stat_t stat,
  output mrs_pkg::ctrl_cmd_t  cmd
);
  import mrs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_ADDR   = 4'd2;
  localparam logic [3:0] S_FUNC   = 4'd3;
  localparam logic [3:0] S_THIRD  = 4'd4;
  localparam logic [3:0] S_BITS   = 4'd5;
  localparam logic [3:0] S_RRD    = 4'd6;
  localparam logic [3:0] S_RHI    = 4'd7;
  localparam logic [3:0] S_RLO    = 4'd8;
  localparam logic [3:0] S_ECHO   = 4'd9;
  localparam logic [3:0] S_WRD_HI = 4'd10;
  localparam logic [3:0] S_WRD_LO = 4'd11;
  localparam logic [3:0] S_WWR    = 4'd12;
  localparam logic [3:0] S_F10    = 4'd13;
  localparam logic [3:0] S_CRCL   = 4'd14;
  localparam logic [3:0] S_CRCH   = 4'd15;

  logic [3:0] state, state_next;
  logic [2:0] plan, plan_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      plan  <= PLAN_DROP;
    end else begin
      state <= state_next;
      plan  <= plan_next;
    end
  end

  always_comb begin
    state_next  = state;
    plan_next   = plan;
    cmd         = '0;
    cmd.rx_open = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (stat.frame_end) state_next = S_DECODE;
      end
      S_DECODE: begin
        plan_next      = stat.plan;
        cmd.resp_start = 1'b1;
        cmd.cnt_clr    = 1'b1;
        unique case (stat.plan)
          PLAN_DROP: begin
            cmd.frame_clear = 1'b1;
            state_next      = S_IDLE;
          end
          PLAN_COIL: begin
            cmd.apply_coil = 1'b1;
            state_next     = S_ECHO;
          end
          PLAN_WRITE_ONE: begin
            cmd.write_one = 1'b1;
            state_next    = S_ECHO;
          end
          PLAN_WRITE_MANY: state_next = S_WRD_HI;
          default:         state_next = S_ADDR;
        endcase
      end
      S_ADDR: begin
        cmd.sel = SEL_ADDR;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_FUNC;
        end
      end
      S_FUNC: begin
        cmd.sel = (plan == PLAN_EXC) ? SEL_EXC_FUNC : SEL_FUNC;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = (plan == PLAN_WRITE_MANY) ? S_F10 : S_THIRD;
        end
      end
      S_THIRD: begin
        cmd.sel = (plan == PLAN_EXC) ? SEL_EXC_CODE : SEL_BYTE_COUNT;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (plan == PLAN_READ_BITS) state_next = S_BITS;
          else if (plan == PLAN_READ_REGS) state_next = S_RRD;
          else state_next = S_CRCL;
        end
      end
      S_BITS: begin
        cmd.sel = SEL_BIT_DATA;
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (stat.cnt_last) state_next = S_CRCL;
        end
      end
      S_RRD: begin
        cmd.reg_rd = 1'b1;
        state_next = S_RHI;
      end
      S_RHI: begin
        cmd.sel = SEL_REG_HI;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_RLO;
        end
      end
      S_RLO: begin
        cmd.sel = SEL_REG_LO;
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = stat.cnt_last ? S_CRCL : S_RRD;
        end
      end
      S_ECHO: begin
        cmd.sel       = SEL_HEAD;
        cmd.emit_last = stat.cnt_last;
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (stat.cnt_last) begin
            cmd.frame_clear = 1'b1;
            state_next      = S_IDLE;
          end
        end
      end
      S_WRD_HI: begin
        cmd.fb_rd_hi = 1'b1;
        state_next   = S_WRD_LO;
      end
      S_WRD_LO: begin
        cmd.fb_rd_lo = 1'b1;
        state_next   = S_WWR;
      end
      S_WWR: begin
        cmd.reg_wr_many = 1'b1;
        cmd.cnt_inc     = 1'b1;
        if (stat.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_ADDR;
        end else begin
          state_next = S_WRD_HI;
        end
      end
      S_F10: begin
        cmd.sel = SEL_F10;
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (stat.quad_end) state_next = S_CRCL;
        end
      end
      S_CRCL: begin
        cmd.sel = SEL_CRC_LO;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_CRCH;
        end
      end
      S_CRCH: begin
        cmd.sel       = SEL_CRC_HI;
        cmd.emit_last = 1'b1;
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.frame_clear = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/mrs_dp.sv =====
`timescale 1ns / 1ps

module mrs_dp #(
  parameter int BIT_DEPTH   = mrs_pkg::BIT_DEPTH_DEF,
  parameter int REG_DEPTH   = mrs_pkg::REG_DEPTH_DEF,
  parameter int FRAME_DEPTH = mrs_pkg::FRAME_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mrs_pkg::cfg_t       cfg,
  input  logic                rx_valid,
  output logic                rx_stall,
  input  mrs_pkg::rx_item_t   rx_item,
  output logic                tx_valid,
  input  logic                tx_stall,
  output mrs_pkg::tx_item_t   tx_item,
  input  mrs_pkg::ctrl_cmd_t  cmd,
  output mrs_pkg::ctrl_stat_t stat
);
  import mrs_pkg::*;

  localparam int FB_AW    = $clog2(FRAME_DEPTH);
  localparam int RAW      = $clog2(REG_DEPTH);
  localparam int BIT_LAST = (BIT_DEPTH - 1 < BIT_LAST_MAX) ? BIT_DEPTH - 1 : BIT_LAST_MAX;
  localparam int REG_LAST = (REG_DEPTH - 1 < REG_LAST_MAX) ? REG_DEPTH - 1 : REG_LAST_MAX;
  localparam logic [15:0]      BIT_LAST_W = 16'(BIT_LAST);
  localparam logic [15:0]      REG_LAST_W = 16'(REG_LAST);
  localparam logic [6:0]       WL_MAX     = 7'(REG_DEPTH - 1);
  localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(FRAME_DEPTH);
  localparam logic [7:0]       PAT_EVEN   = 8'hAA;
  localparam logic [7:0]       PAT_ODD    = 8'h55;

  // ---------------- receive side ----------------
  logic [LEN_W-1:0] length;
  logic [7:0]       quiet;
  logic [15:0]      crc_rx;
  logic [7:0]       prev1, prev2;
  logic [7:0]       head [8];

  logic       rx_take, byte_in, store, tick_in;
  logic [7:0] quiet_inc;

  assign rx_stall  = !cmd.rx_open;
  assign rx_take   = rx_valid && cmd.rx_open;
  assign byte_in   = rx_take && !rx_item.kind;
  assign store     = byte_in && (length < LEN_MAX);
  assign tick_in   = rx_take && rx_item.kind && (length != '0);
  assign quiet_inc = quiet + 8'd1;

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clear) begin
      length <= '0;
      quiet  <= '0;
      crc_rx <= CRC_INIT;
    end else begin
      if (byte_in) quiet <= '0;
      if (tick_in) quiet <= quiet_inc;
      if (store) begin
        length <= length + LEN_W'(1);
        // CRC trails by two bytes so the trailer is left out
        if (length >= LEN_W'(2)) crc_rx <= crc_byte(crc_rx, prev2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      prev2 <= prev1;
      prev1 <= rx_item.rx_data;
      if (length < LEN_W'(8)) head[length[2:0]] <= rx_item.rx_data;
    end
  end

  // ---------------- frame decode ----------------
  logic [7:0]  func, bc;
  logic [15:0] start, qty, last_idx;
  logic [16:0] span, nb_wide;
  logic [6:0]  wl;
  logic        frame_ok, is_bits;
  logic [2:0]  plan;
  logic [7:0]  exc_code, nb, len_byte, loop_len;

  assign func     = head[1];
  assign start    = {head[2], head[3]};
  assign qty      = {head[4], head[5]};
  assign bc       = head[6];
  assign span     = {1'b0, start} + {1'b0, qty};
  assign wl       = ({1'b0, cfg.writable_last} < WL_MAX) ? {1'b0, cfg.writable_last} : WL_MAX;
  assign is_bits  = (func == FC_READ_COILS) || (func == FC_READ_INPUTS);
  assign last_idx = is_bits ? BIT_LAST_W : REG_LAST_W;
  assign frame_ok = (length >= LEN_W'(4)) && ({prev1, prev2} == crc_rx)
                    && (head[0] == cfg.slave_address);

  always_comb begin
    plan     = PLAN_DROP;
    exc_code = EXC_ILLEGAL_FUNCTION;
    if (!frame_ok) begin
      plan = PLAN_DROP;
    end else if (func == FC_READ_COILS || func == FC_READ_INPUTS
                 || func == FC_READ_HOLDING || func == FC_READ_INPUT_REG) begin
      if (length < (is_bits ? LEN_W'(8) : LEN_W'(6))) begin
        plan = PLAN_DROP;
      end else if (start > last_idx) begin
        plan     = PLAN_EXC;
        exc_code = EXC_ILLEGAL_ADDRESS;
      end else if (qty == '0 || span > ({1'b0, last_idx} + 17'd1)) begin
        plan     = PLAN_EXC;
        exc_code = EXC_ILLEGAL_VALUE;
      end else begin
        plan = is_bits ? PLAN_READ_BITS : PLAN_READ_REGS;
      end
    end else if (func == FC_WRITE_COIL) begin
      if (length >= LEN_W'(8) && start <= 16'd1 && (qty == COIL_ON || qty == COIL_OFF))
        plan = PLAN_COIL;
    end else if (func == FC_WRITE_REG) begin
      if (length == LEN_W'(8) && start <= {9'b0, wl}) plan = PLAN_WRITE_ONE;
    end else if (func == FC_WRITE_MULTI) begin
      if (length >= LEN_W'(11) && qty != '0 && span <= ({10'b0, wl} + 17'd1)
          && {qty, 1'b0} == {9'b0, bc}
          && {1'b0, length} >= (10'd9 + {2'b0, bc}))
        plan = PLAN_WRITE_MANY;
    end else begin
      plan     = PLAN_EXC;
      exc_code = EXC_ILLEGAL_FUNCTION;
    end
  end

  assign nb_wide  = {1'b0, qty} + 17'd7;
  assign nb       = nb_wide[10:3];
  assign len_byte = is_bits ? nb : {qty[6:0], 1'b0};

  always_comb begin
    unique case (plan)
      PLAN_READ_BITS:                  loop_len = nb;
      PLAN_READ_REGS, PLAN_WRITE_MANY: loop_len = qty[7:0];
      default:                         loop_len = 8'd8;
    endcase
  end

  // ---------------- loop counter ----------------
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) cnt <= '0;
    else if (cmd.cnt_inc) cnt <= cnt + CNT_W'(1);
  end

  // ---------------- frame buffer ----------------
  logic [8:0]       fb_idx;
  logic [7:0]       fb_q, wr_hi;

  assign fb_idx = 9'd7 + {cnt, 1'b0} + {8'b0, cmd.fb_rd_lo};

  mrs_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (store),
    .waddr (length[FB_AW-1:0]),
    .wdata (rx_item.rx_data),
    .re    (cmd.fb_rd_hi || cmd.fb_rd_lo),
    .raddr (fb_idx[FB_AW-1:0]),
    .q     (fb_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.fb_rd_lo) wr_hi <= fb_q;
  end

  // ---------------- holding registers ----------------
  // unwritten entries read back as index * 100
  logic [REG_DEPTH-1:0] reg_valid;
  logic [15:0]          start_cnt, reg_q, reg_word, reg_wdata;
  logic [RAW-1:0]       reg_waddr, reg_rd_addr;
  logic                 reg_we, reg_rd_valid;

  assign start_cnt = start + 16'(cnt);
  assign reg_we    = cmd.write_one || cmd.reg_wr_many;
  assign reg_waddr = cmd.write_one ? start[RAW-1:0] : start_cnt[RAW-1:0];
  assign reg_wdata = cmd.write_one ? qty : {wr_hi, fb_q};

  mrs_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_reg_ram (
    .clk   (clk),
    .we    (reg_we),
    .waddr (reg_waddr),
    .wdata (reg_wdata),
    .re    (cmd.reg_rd),
    .raddr (start_cnt[RAW-1:0]),
    .q     (reg_q)
  );

  always_ff @(posedge clk) begin
    if (rst) reg_valid <= '0;
    else if (reg_we) reg_valid[reg_waddr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.reg_rd) begin
      reg_rd_valid <= reg_valid[start_cnt[RAW-1:0]];
      reg_rd_addr  <= start_cnt[RAW-1:0];
    end
  end

  assign reg_word = reg_rd_valid ? reg_q : (16'(reg_rd_addr) * REG_INIT_STEP);

  // ---------------- LED coils ----------------
  logic [1:0] led, coil_bit;

  assign coil_bit = start[0] ? 2'b10 : 2'b01;

  always_ff @(posedge clk) begin
    if (rst) led <= '0;
    else if (cmd.apply_coil) led <= (qty == COIL_ON) ? (led | coil_bit) : (led & ~coil_bit);
  end

  // ---------------- response bytes ----------------
  logic [15:0] rem, tx_crc;
  logic [7:0]  bit_mask, bit_byte, tx_byte;

  assign rem      = qty - 16'({cnt, 3'b000});
  assign bit_mask = (rem >= 16'd8) ? 8'hFF : ~(8'hFF << rem[2:0]);
  assign bit_byte = (start[0] ? PAT_ODD : PAT_EVEN) & bit_mask;

  always_comb begin
    unique case (cmd.sel)
      SEL_ADDR:       tx_byte = cfg.slave_address;
      SEL_FUNC:       tx_byte = func;
      SEL_EXC_FUNC:   tx_byte = func | EXC_FLAG;
      SEL_EXC_CODE:   tx_byte = exc_code;
      SEL_BYTE_COUNT: tx_byte = len_byte;
      SEL_BIT_DATA:   tx_byte = bit_byte;
      SEL_REG_HI:     tx_byte = reg_word[15:8];
      SEL_REG_LO:     tx_byte = reg_word[7:0];
      SEL_HEAD:       tx_byte = head[cnt[2:0]];
      SEL_F10: begin
        unique case (cnt[1:0])
          2'd0:    tx_byte = start[15:8];
          2'd1:    tx_byte = start[7:0];
          2'd2:    tx_byte = qty[15:8];
          default: tx_byte = qty[7:0];
        endcase
      end
      SEL_CRC_LO:     tx_byte = tx_crc[7:0];
      SEL_CRC_HI:     tx_byte = tx_crc[15:8];
      default:        tx_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_start) tx_crc <= CRC_INIT;
    else if (cmd.emit && cmd.sel != SEL_CRC_LO && cmd.sel != SEL_CRC_HI)
      tx_crc <= crc_byte(tx_crc, tx_byte);
  end

  // ---------------- chunk packing and output register ----------------
  logic [2:0]  fill;
  logic [3:0]  fill_next;
  logic [63:0] chunk, chunk_next;
  logic        flush;

  assign fill_next  = {1'b0, fill} + 4'd1;
  assign chunk_next = chunk | (64'(tx_byte) << {fill, 3'b000});
  assign flush      = cmd.emit && (fill_next == 4'd8 || cmd.emit_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      tx_valid <= 1'b0;
    end else begin
      if (tx_valid && !tx_stall) tx_valid <= 1'b0;
      if (cmd.emit) begin
        if (flush) begin
          fill     <= '0;
          tx_valid <= 1'b1;
        end else begin
          fill <= fill_next[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_start) begin
      chunk <= '0;
    end else if (cmd.emit) begin
      if (flush) begin
        chunk   <= '0;
        tx_item <= '{tx_bytes: chunk_next, tx_count: fill_next,
                     last: cmd.emit_last, led_state: led};
      end else begin
        chunk <= chunk_next;
      end
    end
  end

  // ---------------- status ----------------
  always_comb begin
    stat           = '0;
    stat.frame_end = tick_in && !(quiet_inc < cfg.silence_ticks);
    stat.out_free  = !tx_valid || !tx_stall;
    stat.plan      = plan;
    stat.cnt_last  = (cnt == loop_len - CNT_W'(1));
    stat.quad_end  = (cnt[1:0] == 2'b11);
  end

  assert property (@(posedge clk) disable iff (rst)
    tx_valid |-> (tx_item.tx_count != 4'd0 && tx_item.tx_count <= 4'd8))
    else $error("chunk byte count out of range");

  assert property (@(posedge clk) disable iff (rst) length <= LEN_MAX)
    else $error("frame length past buffer depth");

  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> stat.out_free)
    else $error("byte emitted while output register blocked");

  assert property (@(posedge clk) disable iff (rst)
    (tx_valid && tx_item.last) |-> (fill == 3'd0))
    else $error("bytes left in packer after final chunk");

endmodule

// ===== design/modbus_rtu_slave_top.sv =====
`timescale 1ns / 1ps

// Channel  | Signals                                   | Moves
// rx       | rx_valid, rx_stall, rx_item               | one received byte or silence tick
// tx       | tx_valid, tx_stall, tx_item               | up to 8 response bytes
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// A byte or tick item is taken whenever the block is idle.
// The tick that ends a frame stalls rx until the last response chunk is in the
// output register: a decode state, then each response byte in turn, plus one
// RAM read per register read and, per register written by function 10, two
// frame buffer reads and one write. A dropped frame costs only decode.
// Synchronous reset; holding registers read back index*100 until written
// (per-entry valid bits, no clearing pass). A stalled tx holds the packer.

module modbus_rtu_slave_top #(
  parameter int BIT_DEPTH   = mrs_pkg::BIT_DEPTH_DEF,
  parameter int REG_DEPTH   = mrs_pkg::REG_DEPTH_DEF,
  parameter int FRAME_DEPTH = mrs_pkg::FRAME_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rx_valid,
  output logic                          rx_stall,
  input  mrs_pkg::rx_item_t             rx_item,
  output logic                          tx_valid,
  input  logic                          tx_stall,
  output mrs_pkg::tx_item_t             tx_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import mrs_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Registers are to be written only while idle; the block does not enforce this, so writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address <= 8'd1;
      cfg.silence_ticks <= 8'd4;
      cfg.writable_last <= 6'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDRESS: cfg.slave_address <= cfg_data;
        CFG_SILENCE_TICKS: cfg.silence_ticks <= cfg_data;
        CFG_WRITABLE_LAST: cfg.writable_last <= cfg_data[5:0];
        default: ;  // unused index: write is dropped
      endcase
    end
  end

  // Sequencer: frame end detection to final chunk
  mrs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Frame capture, CRC, decode, register file and response packer
  mrs_dp #(
    .BIT_DEPTH   (BIT_DEPTH),
    .REG_DEPTH   (REG_DEPTH),
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_item  (rx_item),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx_item  (tx_item),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ===== dv/modbus_rtu_slave_top_tb.sv =====
`timescale 1ns / 1ps

module modbus_rtu_slave_top_tb;
  import mrs_pkg::*;

  localparam int BITS_N   = 1024;
  localparam int REGS_N   = 64;
  localparam int FRAME_N  = 256;
  localparam int BIT_TOP  = 999;   // last readable bit index
  localparam int REG_TOP  = 63;    // last readable register index
  localparam int SETTLE   = 1500;  // cycles a dropped frame may still be busy

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_valid = 1'b0;
  logic rx_stall;
  rx_item_t rx_item = '0;
  logic tx_valid;
  logic tx_stall = 1'b0;
  tx_item_t tx_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  modbus_rtu_slave_top uut (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_item(rx_item),
    .tx_valid(tx_valid), .tx_stall(tx_stall), .tx_item(tx_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow of the slave: config, frame assembly, data tables
  logic [7:0]  my_addr;
  logic [7:0]  my_ticks;
  logic [5:0]  my_wlast;
  logic [7:0]  fbuf [FRAME_N];
  int          flen;
  logic [7:0]  quiet;
  bit          coil_tab [BITS_N];
  logic [15:0] hregs [REGS_N];
  logic [1:0]  leds;
  logic [7:0]  reply [$];

  tx_item_t replies_q [$];
  int       errors = 0;
  int       sent_items = 0;
  bit       rx_gaps = 1'b1;
  bit       calm = 1'b0;      // no idling on either side
  bit       long_hold = 1'b0; // request for one long tx hold-off
  int       frame_replies;
  logic [63:0] frame_first;

  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
    c = c ^ {8'h00, d};
    for (int b = 0; b < 8; b++)
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic int fword(int i);
    return {fbuf[i], fbuf[i + 1]};
  endfunction

  function automatic void seal_reply();
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (reply[i]) c = crc_next(c, reply[i]);
    reply.push_back(c[7:0]);
    reply.push_back(c[15:8]);
  endfunction

  function automatic void refuse(logic [7:0] fc, logic [7:0] code);
    reply = {my_addr, fc | EXC_FLAG, code};
    seal_reply();
  endfunction

  // Decide what a finished frame answers; leaves bytes in reply
  function automatic void serve_frame();
    int n, start, qty, lim, nb, wl, val, bc;
    logic [7:0] fc;
    logic [15:0] c;
    n = flen;
    reply = {};
    if (n < 4) return;
    c = 16'hFFFF;
    for (int i = 0; i < n - 2; i++) c = crc_next(c, fbuf[i]);
    if ({fbuf[n - 1], fbuf[n - 2]} != c) return;
    if (fbuf[0] != my_addr) return;
    fc = fbuf[1];
    wl = (my_wlast < REGS_N - 1) ? my_wlast : REGS_N - 1;
    if (fc == FC_READ_COILS || fc == FC_READ_INPUTS ||
        fc == FC_READ_HOLDING || fc == FC_READ_INPUT_REG) begin
      lim = (fc <= FC_READ_INPUTS) ? BIT_TOP : REG_TOP;
      if (n < ((fc <= FC_READ_INPUTS) ? 8 : 6)) return;
      start = fword(2);
      qty = fword(4);
      if (start > lim) begin
        refuse(fc, EXC_ILLEGAL_ADDRESS);
        return;
      end
      if (qty == 0 || start + qty - 1 > lim) begin
        refuse(fc, EXC_ILLEGAL_VALUE);
        return;
      end
      reply = {my_addr, fc};
      if (fc <= FC_READ_INPUTS) begin
        nb = (qty + 7) / 8;
        reply.push_back(nb[7:0]);
        for (int i = 0; i < nb; i++) reply.push_back(8'h00);
        for (int i = 0; i < qty; i++)
          if (coil_tab[start + i]) reply[3 + i / 8][i % 8] = 1'b1;
      end else begin
        nb = qty * 2;
        reply.push_back(nb[7:0]);
        for (int i = 0; i < qty; i++) begin
          reply.push_back(hregs[start + i][15:8]);
          reply.push_back(hregs[start + i][7:0]);
        end
      end
      seal_reply();
    end else if (fc == FC_WRITE_COIL) begin
      if (n < 8) return;
      start = fword(2);
      val = fword(4);
      if (start > 1 || (val != COIL_ON && val != COIL_OFF)) return;
      leds[start] = (val == COIL_ON);
      for (int i = 0; i < 8; i++) reply.push_back(fbuf[i]);
    end else if (fc == FC_WRITE_REG) begin
      if (n != 8) return;
      start = fword(2);
      if (start > wl) return;
      hregs[start] = fword(4);
      for (int i = 0; i < 8; i++) reply.push_back(fbuf[i]);
    end else if (fc == FC_WRITE_MULTI) begin
      if (n < 11) return;
      start = fword(2);
      qty = fword(4);
      bc = fbuf[6];
      if (qty == 0 || start + qty - 1 > wl) return;
      if (qty * 2 != bc || n < 9 + bc) return;
      for (int i = 0; i < qty; i++) hregs[start + i] = fword(7 + 2 * i);
      reply = {my_addr, FC_WRITE_MULTI, start[15:8], start[7:0], qty[15:8], qty[7:0]};
      seal_reply();
    end else begin
      refuse(fc, EXC_ILLEGAL_FUNCTION);
    end
  endfunction

  // Called once per accepted rx item
  function automatic void track_item(rx_item_t it);
    tx_item_t r;
    int take;
    if (!it.kind) begin
      if (flen < FRAME_N) begin
        fbuf[flen] = it.rx_data;
        flen++;
      end
      quiet = 0;
      return;
    end
    if (flen == 0) return;
    quiet++;
    if (quiet < my_ticks) return;
    serve_frame();
    flen = 0;
    quiet = 0;
    frame_replies = 0;
    for (int pos = 0; pos < reply.size(); pos += 8) begin
      take = (reply.size() - pos < 8) ? reply.size() - pos : 8;
      r = '0;
      for (int k = 0; k < take; k++) r.tx_bytes[8 * k +: 8] = reply[pos + k];
      r.tx_count = take;
      r.last = (pos + take >= reply.size());
      r.led_state = leds;
      if (frame_replies == 0) frame_first = r.tx_bytes;
      frame_replies++;
      replies_q.push_back(r);
    end
  endfunction

  // Checker on tx
  always @(posedge clk) begin
    tx_item_t e;
    if (!rst && tx_valid && !tx_stall) begin
      if (replies_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply chunk, expected none, got %h", $time, tx_item);
      end else begin
        e = replies_q.pop_front();
        if (tx_item.tx_bytes !== e.tx_bytes) begin
          errors++;
          $display("%0t: tx_bytes expected %h got %h", $time, e.tx_bytes, tx_item.tx_bytes);
        end
        if (tx_item.tx_count !== e.tx_count) begin
          errors++;
          $display("%0t: tx_count expected %0d got %0d", $time, e.tx_count, tx_item.tx_count);
        end
        if (tx_item.last !== e.last) begin
          errors++;
          $display("%0t: last expected %b got %b", $time, e.last, tx_item.last);
        end
        if (tx_item.led_state !== e.led_state) begin
          errors++;
          $display("%0t: led_state expected %b got %b", $time, e.led_state,
                   tx_item.led_state);
        end
      end
    end
  end

  // Receiver stalls: random bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        tx_stall <= 1'b1;
        repeat (400) @(posedge clk);
        tx_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        tx_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        tx_stall <= 1'b0;
      end
    end
  end

  // Send one item; valid stays high into the next call unless a gap is taken
  task automatic send_item(input logic kind, input logic [7:0] data);
    rx_item_t it;
    it.kind = kind;
    it.rx_data = data;
    if (rx_gaps && !calm && $urandom_range(0, 3) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    rx_item <= it;
    rx_valid <= 1'b1;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    track_item(it);
    sent_items++;
  endtask

  // Ticks (random data riding along) until the current frame is served
  task automatic close_frame();
    while (flen != 0) send_item(1'b1, $urandom_range(0, 255));
  endtask

  task automatic send_frame(input logic [7:0] bytes [$], input bit bad_crc);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (bytes[i]) c = crc_next(c, bytes[i]);
    if (bad_crc) c[$urandom_range(0, 15)] ^= 1'b1;
    foreach (bytes[i]) send_item(1'b0, bytes[i]);
    send_item(1'b0, c[7:0]);
    send_item(1'b0, c[15:8]);
    close_frame();
  endtask

  // Idle the block, then write all three registers
  task automatic set_config(input logic [7:0] a, input logic [7:0] t, input logic [5:0] w);
    logic [7:0] vals [3];
    logic [CFG_IDX_W-1:0] idx [3];
    vals = '{a, t, {2'b00, w}};
    idx = '{CFG_SLAVE_ADDRESS, CFG_SILENCE_TICKS, CFG_WRITABLE_LAST};
    close_frame();
    rx_valid <= 1'b0;
    wait (replies_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (idx[i] == CFG_SLAVE_ADDRESS) my_addr = vals[i];
      else if (idx[i] == CFG_SILENCE_TICKS) my_ticks = vals[i];
      else my_wlast = vals[i][5:0];
    end
    cfg_valid <= 1'b0;
  endtask

  // One random request: mostly well formed, some broken or foreign
  task automatic random_frame();
    logic [7:0] f [$];
    logic [7:0] fc;
    int sel, start, qty, lim, wl;
    bit bad;
    sel = $urandom_range(0, 9);
    wl = my_wlast;
    f.push_back(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : my_addr);
    case (sel)
      0, 1, 2, 3: begin
        fc = (sel == 0) ? FC_READ_COILS : (sel == 1) ? FC_READ_INPUTS :
             (sel == 2) ? FC_READ_HOLDING : FC_READ_INPUT_REG;
        lim = (sel < 2) ? BIT_TOP : REG_TOP;
        start = ($urandom_range(0, 7) != 0) ? $urandom_range(0, lim) : $urandom_range(0, 65535);
        case ($urandom_range(0, 9))
          0: qty = 0;
          1: qty = $urandom_range(0, 65535);
          2: qty = (start <= lim) ? lim + 1 - start : 1;
          default: qty = $urandom_range(1, 20);
        endcase
        f.push_back(fc);
        f.push_back(start[15:8]); f.push_back(start[7:0]);
        f.push_back(qty[15:8]);   f.push_back(qty[7:0]);
      end
      4: begin
        start = $urandom_range(0, 2);
        qty = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) :
              ($urandom_range(0, 1) ? COIL_ON : COIL_OFF);
        f.push_back(FC_WRITE_COIL);
        f.push_back(8'h00); f.push_back(start[7:0]);
        f.push_back(qty[15:8]); f.push_back(qty[7:0]);
      end
      5: begin
        start = $urandom_range(0, wl + 2);
        qty = $urandom_range(0, 65535);
        f.push_back(FC_WRITE_REG);
        f.push_back(start[15:8]); f.push_back(start[7:0]);
        f.push_back(qty[15:8]);   f.push_back(qty[7:0]);
      end
      6, 7: begin
        start = $urandom_range(0, wl);
        qty = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 4);
        f.push_back(FC_WRITE_MULTI);
        f.push_back(start[15:8]); f.push_back(start[7:0]);
        f.push_back(qty[15:8]);   f.push_back(qty[7:0]);
        f.push_back(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : 2 * qty);
        for (int i = 0; i < 2 * qty; i++) f.push_back($urandom_range(0, 255));
      end
      default: begin
        f.push_back($urandom_range(0, 255));
        repeat ($urandom_range(0, 6)) f.push_back($urandom_range(0, 255));
      end
    endcase
    // occasional truncation or stray tail byte
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) && f.size() > 1) void'(f.pop_back());
      else f.push_back($urandom_range(0, 255));
    end
    bad = ($urandom_range(0, 9) == 0);
    send_frame(f, bad);
  endtask

  task automatic random_phase(input int budget);
    int stop;
    stop = sent_items + budget;
    while (sent_items < stop) random_frame();
  endtask

  // Directed requests: n body bytes, CRC appended (flipped when bad);
  // head holds the opening reply bytes where they are obvious (hlen 0: none)
  typedef struct packed {
    logic [3:0]  n;
    logic        bad;
    logic [2:0]  hlen;
    logic [31:0] head;
    logic [87:0] body;
  } req_row_t;

  localparam int NROWS = 23;
  req_row_t rows [NROWS];

  initial begin
    logic [7:0] f [$];
    logic [31:0] mask;
    my_addr = 8'd1;
    my_ticks = 8'd4;
    my_wlast = 6'd3;
    flen = 0;
    quiet = 0;
    leds = 2'b00;
    for (int i = 0; i < BITS_N; i++) coil_tab[i] = i[0];
    for (int i = 0; i < REGS_N; i++) hregs[i] = i * 100;

    // coils after reset: odd indexes set
    rows[0]  = '{4'd6, 1'b0, 3'd4, 32'hAA010101, {8'h01, FC_READ_COILS, 16'd0, 16'd8, 40'd0}};
    rows[1]  = '{4'd6, 1'b0, 3'd4, 32'h01010201, {8'h01, FC_READ_INPUTS, 16'd999, 16'd1, 40'd0}};
    rows[2]  = '{4'd6, 1'b0, 3'd3, 32'h00028101, {8'h01, FC_READ_COILS, 16'd1000, 16'd1, 40'd0}};
    rows[3]  = '{4'd6, 1'b0, 3'd3, 32'h00038301, {8'h01, FC_READ_HOLDING, 16'd0, 16'd0, 40'd0}};
    rows[4]  = '{4'd6, 1'b0, 3'd4, 32'h18020401, {8'h01, FC_READ_INPUT_REG, 16'd63, 16'd1, 40'd0}};
    rows[5]  = '{4'd6, 1'b0, 3'd0, 32'h0, {8'h01, FC_READ_HOLDING, 16'd62, 16'd2, 40'd0}};
    rows[6]  = '{4'd6, 1'b0, 3'd3, 32'h00028301, {8'h01, FC_READ_HOLDING, 16'd64, 16'd1, 40'd0}};
    rows[7]  = '{4'd6, 1'b0, 3'd3, 32'h00038101, {8'h01, FC_READ_COILS, 16'd998, 16'd3, 40'd0}};
    rows[8]  = '{4'd6, 1'b0, 3'd4, 32'h01000501, {8'h01, FC_WRITE_COIL, 16'd1, COIL_ON, 40'd0}};
    rows[9]  = '{4'd6, 1'b0, 3'd0, 32'h0, {8'h01, FC_WRITE_COIL, 16'd2, COIL_ON, 40'd0}};
    rows[10] = '{4'd6, 1'b0, 3'd0, 32'h0, {8'h01, FC_WRITE_COIL, 16'd0, 16'h1234, 40'd0}};
    rows[11] = '{4'd6, 1'b0, 3'd4, 32'h01000501, {8'h01, FC_WRITE_COIL, 16'd1, COIL_OFF, 40'd0}};
    rows[12] = '{4'd6, 1'b0, 3'd4, 32'h03000601, {8'h01, FC_WRITE_REG, 16'd3, 16'hFFFF, 40'd0}};
    rows[13] = '{4'd6, 1'b0, 3'd0, 32'h0, {8'h01, FC_WRITE_REG, 16'd4, 16'h0001, 40'd0}};
    rows[14] = '{4'd11, 1'b0, 3'd4, 32'h00001001,
                 {8'h01, FC_WRITE_MULTI, 16'd0, 16'd2, 8'd4, 16'hAAAA, 16'h5555}};
    rows[15] = '{4'd11, 1'b0, 3'd0, 32'h0, {8'h01, FC_WRITE_MULTI, 16'd0, 16'd0, 8'd0, 32'd0}};
    rows[16] = '{4'd11, 1'b0, 3'd0, 32'h0, {8'h01, FC_WRITE_MULTI, 16'd0, 16'd2, 8'd3, 32'd0}};
    rows[17] = '{4'd9, 1'b0, 3'd0, 32'h0,
                 {8'h01, FC_WRITE_MULTI, 16'd0, 16'd2, 8'd4, 16'h1234, 16'd0}};
    rows[18] = '{4'd6, 1'b0, 3'd3, 32'h0001AB01, {8'h01, 8'h2B, 16'd0, 16'd1, 40'd0}};
    rows[19] = '{4'd6, 1'b0, 3'd3, 32'h0001FF01, {8'h01, 8'hFF, 16'hFFFF, 16'hFFFF, 40'd0}};
    rows[20] = '{4'd6, 1'b0, 3'd0, 32'h0, {8'h02, FC_READ_COILS, 16'd0, 16'd8, 40'd0}};
    rows[21] = '{4'd6, 1'b1, 3'd0, 32'h0, {8'h01, FC_READ_COILS, 16'd0, 16'd8, 40'd0}};
    rows[22] = '{4'd1, 1'b0, 3'd0, 32'h0, {8'h01, 80'd0}};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // ticks with nothing buffered do nothing
    repeat (3) send_item(1'b1, 8'hFF);

    for (int r = 0; r < NROWS; r++) begin
      // from here on a single tick closes a frame
      if (r == 5) set_config(8'd1, 8'd1, 6'd3);
      f = {};
      for (int k = 0; k < rows[r].n; k++) f.push_back(rows[r].body[87 - 8 * k -: 8]);
      frame_replies = 0;
      send_frame(f, rows[r].bad);
      if (rows[r].hlen != 0) begin
        mask = (rows[r].hlen == 4) ? 32'hFFFFFFFF : 32'h00FFFFFF;
        if (frame_replies == 0 || (frame_first[31:0] & mask) != rows[r].head) begin
          errors++;
          $display("%0t: request %0d reply head expected %h got %h", $time, r,
                   rows[r].head, frame_first[31:0] & mask);
        end
      end
    end
    // short read-register request and a long single write
    send_frame('{8'h01, FC_READ_HOLDING, 8'h00}, 1'b0);
    send_frame('{8'h01, FC_WRITE_REG, 8'h00, 8'h02, 8'h00, 8'h05, 8'h00}, 1'b0);

    // widest address, single-tick frame end, all registers writable;
    // the receiver holds off long enough to back the block up
    set_config(8'd247, 8'd1, 6'd63);
    long_hold = 1'b1;
    random_phase(25);
    // 999-bit read, the longest reply any bit read gives
    send_frame('{8'd247, FC_READ_COILS, 8'h00, 8'h00, 8'h03, 8'hE7}, 1'b0);

    // long silence, only register 0 writable
    set_config(8'h5A, 8'd9, 6'd0);
    repeat (2) random_frame();

    // zero silence acts as one tick
    set_config(8'h11, 8'd0, 6'd20);
    random_phase(10);
    close_frame();
    rx_valid <= 1'b0;
    wait (replies_q.size() == 0);
    repeat (40) @(posedge clk);
    random_phase(10);

    // last stretch with no idling on either side
    set_config($urandom_range(1, 247), 8'd2, $urandom_range(0, 63));
    calm = 1'b1;
    random_phase(25);
    close_frame();
    rx_valid <= 1'b0;

    wait (replies_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("Mismatches found");
    $finish;
  end

endmodule
